// ===== rtl/core/solenoid_pulse_scheduler_core_defines.svh =====
// Assertion macros shared by the checker of the solenoid pulse scheduler.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef SOLENOID_PULSE_SCHEDULER_CORE_DEFINES_SVH
`define SOLENOID_PULSE_SCHEDULER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SPS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/sps_pkg.sv =====
package sps_pkg;

	localparam int QUEUE_DEPTH = 8;
	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int DLY_W = 16;
	localparam int DIR_W = 2;
	localparam int ACT_W = 2;
	localparam int SUM_W = DLY_W + CNT_W;
	localparam int QCNT_W = 4;

	localparam logic [ACT_W-1:0] ACT_TICK   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_ON     = 2'd1;
	localparam logic [ACT_W-1:0] ACT_OFF    = 2'd2;
	localparam logic [ACT_W-1:0] ACT_FORGET = 2'd3;

	localparam logic [DIR_W-1:0] DIR_NONE    = 2'd0;
	localparam logic [DIR_W-1:0] DIR_INVALID = 2'd3;

	localparam logic [1:0] REG_TWO_POINT = 2'd0;
	localparam logic [1:0] REG_PULSE_LEN = 2'd1;
	localparam logic [1:0] REG_QUEUE_EN  = 2'd2;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_TICK_PULSE,
		OP_TICK_DELAY,
		OP_APPLY_PEND,
		OP_START_ON,
		OP_OFF,
		OP_FORGET,
		OP_ERR,
		OP_SUM_INIT,
		OP_SUM_STEP,
		OP_Q_WRITE,
		OP_POP,
		OP_OUT
	} op_t;

	typedef struct packed {
		logic             two_point;
		logic [DLY_W-1:0] pulse_len;
		logic             queue_en;
	} cfg_t;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [DLY_W-1:0] delay_ticks;
		logic [DIR_W-1:0] direction;
	} item_t;

	typedef struct packed {
		logic [DIR_W-1:0] dir;
		logic [DLY_W-1:0] delay;
	} slot_t;

	typedef struct packed {
		logic              coil_on;
		logic [DIR_W-1:0]  coil_direction;
		logic              off_event;
		logic              error_event;
		logic [QCNT_W-1:0] queue_count;
	} result_t;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic             queue_busy;
		logic             full;
		logic             expired;
		logic             drain_go;
		logic             sum_done;
	} stat_t;

	// Queue pointer advance with wrap; b never exceeds QUEUE_DEPTH.
	function automatic logic [PTR_W-1:0] ptr_add(logic [PTR_W-1:0] a, logic [CNT_W-1:0] b);
		logic [CNT_W:0] s;
		s = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
		if (s >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
			s = s - (CNT_W + 1)'(QUEUE_DEPTH);
		end
		return s[PTR_W-1:0];
	endfunction

endpackage

// ===== rtl/core/sps_ctrl.sv =====
module sps_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  sps_pkg::stat_t stat,
	output sps_pkg::op_t   op
);
	import sps_pkg::*;

	localparam logic [3:0] ST_IDLE      = 4'd0;
	localparam logic [3:0] ST_DISPATCH  = 4'd1;
	localparam logic [3:0] ST_TICK_DLY  = 4'd2;
	localparam logic [3:0] ST_APPLY     = 4'd3;
	localparam logic [3:0] ST_DRAIN_RD  = 4'd4;
	localparam logic [3:0] ST_DRAIN_POP = 4'd5;
	localparam logic [3:0] ST_SUM       = 4'd6;
	localparam logic [3:0] ST_QWR       = 4'd7;
	localparam logic [3:0] ST_FINISH    = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       out_load;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign out_load = (state_q == ST_FINISH) && (!out_valid_q || m_tready);

	always_comb begin
		state_d = state_q;
		op = OP_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					op = OP_LOAD;
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				unique case (stat.action)
					ACT_TICK: begin
						op = OP_TICK_PULSE;
						state_d = ST_TICK_DLY;
					end
					ACT_ON: begin
						if (stat.queue_busy && stat.full) begin
							op = OP_ERR;
							state_d = ST_FINISH;
						end else if (stat.queue_busy) begin
							op = OP_SUM_INIT;
							state_d = ST_SUM;
						end else begin
							op = OP_START_ON;
							state_d = ST_FINISH;
						end
					end
					ACT_OFF: begin
						op = OP_OFF;
						state_d = ST_FINISH;
					end
					default: begin
						op = OP_FORGET;
						state_d = ST_FINISH;
					end
				endcase
			end
			ST_TICK_DLY: begin
				op = OP_TICK_DELAY;
				state_d = stat.expired ? ST_APPLY : ST_FINISH;
			end
			ST_APPLY: begin
				op = OP_APPLY_PEND;
				state_d = ST_DRAIN_RD;
			end
			ST_DRAIN_RD: begin
				state_d = stat.drain_go ? ST_DRAIN_POP : ST_FINISH;
			end
			ST_DRAIN_POP: begin
				op = OP_POP;
				state_d = ST_DRAIN_RD;
			end
			ST_SUM: begin
				op = OP_SUM_STEP;
				if (stat.sum_done) begin
					state_d = ST_QWR;
				end
			end
			ST_QWR: begin
				op = OP_Q_WRITE;
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_load) begin
					op = OP_OUT;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/sps_dp.sv =====
module sps_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  sps_pkg::cfg_t    cfg,
	input  sps_pkg::item_t   item,
	input  sps_pkg::op_t     op,
	output sps_pkg::stat_t   stat,
	output sps_pkg::result_t result
);
	import sps_pkg::*;

	// Item under work.
	logic [ACT_W-1:0] act_q;
	logic [DLY_W-1:0] dly_q;
	logic [DIR_W-1:0] dir_q;

	// Coil and timer state.
	logic             energized_q;
	logic [DIR_W-1:0] cur_dir_q;
	logic [DIR_W-1:0] pend_dir_q;
	logic [DLY_W-1:0] delay_left_q;
	logic             delay_run_q;
	logic [DLY_W-1:0] pulse_left_q;
	logic             pulse_run_q;
	logic             off_q;
	logic             err_q;

	// Command queue.
	slot_t            mem_q [QUEUE_DEPTH];
	slot_t            rd_data_q;
	logic [PTR_W-1:0] head_q;
	logic [CNT_W-1:0] fill_q;
	logic [PTR_W-1:0] rd_addr;
	logic [PTR_W-1:0] wr_addr;

	// Scheduled-time accumulator.
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] idx_q;
	logic             pipe_v_q;
	logic [DLY_W-1:0] q_delay;

	result_t          result_q;

	logic [DIR_W-1:0] en_dir;
	logic [DLY_W-1:0] start_dly;
	logic             en_ok;
	logic             do_en;
	logic [CNT_W+QCNT_W-1:0] fill_ext;

	assign rd_addr = ptr_add(head_q, idx_q);
	assign wr_addr = ptr_add(head_q, fill_q);

	always_comb begin
		if (op == OP_APPLY_PEND) begin
			en_dir = pend_dir_q;
		end else if (op == OP_POP) begin
			en_dir = rd_data_q.dir;
		end else begin
			en_dir = dir_q;
		end
		start_dly = (op == OP_POP) ? rd_data_q.delay : dly_q;
		en_ok = !cfg.two_point || (en_dir != cur_dir_q);
		do_en = (op == OP_APPLY_PEND) ||
			(((op == OP_START_ON) || (op == OP_POP)) && (start_dly == '0));
		if ((SUM_W)'(dly_q) > sum_q) begin
			q_delay = dly_q - sum_q[DLY_W-1:0];
		end else begin
			q_delay = '0;
		end
	end

	assign stat.action     = act_q;
	assign stat.queue_busy = cfg.queue_en && delay_run_q;
	assign stat.full       = (fill_q == CNT_W'(QUEUE_DEPTH));
	assign stat.expired    = delay_run_q && (delay_left_q <= DLY_W'(1));
	assign stat.drain_go   = (fill_q != '0) && !delay_run_q;
	assign stat.sum_done   = (idx_q == fill_q) && !pipe_v_q;

	assign fill_ext = (CNT_W + QCNT_W)'(fill_q);
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			energized_q <= 1'b0;
			cur_dir_q <= DIR_NONE;
			pend_dir_q <= DIR_NONE;
			delay_left_q <= '0;
			delay_run_q <= 1'b0;
			pulse_left_q <= '0;
			pulse_run_q <= 1'b0;
			off_q <= 1'b0;
			err_q <= 1'b0;
			head_q <= '0;
			fill_q <= '0;
			idx_q <= '0;
			pipe_v_q <= 1'b0;
		end else begin
			unique case (op)
				OP_LOAD: begin
					off_q <= 1'b0;
					err_q <= 1'b0;
					idx_q <= '0;
				end
				OP_TICK_PULSE: begin
					if (pulse_run_q) begin
						if (pulse_left_q != '0) begin
							pulse_left_q <= pulse_left_q - DLY_W'(1);
						end
						if (pulse_left_q <= DLY_W'(1)) begin
							pulse_run_q <= 1'b0;
							if (energized_q) begin
								energized_q <= 1'b0;
								off_q <= 1'b1;
							end
						end
					end
				end
				OP_TICK_DELAY: begin
					if (delay_run_q) begin
						if (delay_left_q != '0) begin
							delay_left_q <= delay_left_q - DLY_W'(1);
						end
						if (delay_left_q <= DLY_W'(1)) begin
							delay_run_q <= 1'b0;
						end
					end
				end
				OP_START_ON, OP_POP: begin
					if (start_dly != '0) begin
						pend_dir_q <= en_dir;
						delay_left_q <= start_dly;
						delay_run_q <= 1'b1;
					end
					if (op == OP_POP) begin
						head_q <= ptr_add(head_q, CNT_W'(1));
						fill_q <= fill_q - CNT_W'(1);
					end
				end
				OP_OFF: begin
					if (energized_q) begin
						pulse_run_q <= 1'b0;
						pulse_left_q <= '0;
						energized_q <= 1'b0;
					end
				end
				OP_FORGET: begin
					cur_dir_q <= DIR_NONE;
				end
				OP_ERR: begin
					err_q <= 1'b1;
				end
				OP_SUM_INIT: begin
					idx_q <= '0;
					pipe_v_q <= 1'b0;
				end
				OP_SUM_STEP: begin
					if (idx_q < fill_q) begin
						idx_q <= idx_q + CNT_W'(1);
						pipe_v_q <= 1'b1;
					end else begin
						pipe_v_q <= 1'b0;
					end
				end
				OP_Q_WRITE: begin
					fill_q <= fill_q + CNT_W'(1);
				end
				default: begin
				end
			endcase
			// Energizing overrides the timer updates of the same cycle.
			if (do_en && en_ok) begin
				cur_dir_q <= en_dir;
				energized_q <= 1'b1;
				if (cfg.pulse_len != '0) begin
					pulse_left_q <= cfg.pulse_len;
					pulse_run_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
		if (op == OP_Q_WRITE) begin
			mem_q[wr_addr] <= '{dir: dir_q, delay: q_delay};
		end
		if (op == OP_LOAD) begin
			act_q <= item.action;
			dly_q <= item.delay_ticks;
			dir_q <= (item.direction == DIR_INVALID) ? DIR_NONE : item.direction;
		end
		if (op == OP_SUM_INIT) begin
			sum_q <= (SUM_W)'(delay_left_q);
		end else if ((op == OP_SUM_STEP) && pipe_v_q) begin
			sum_q <= sum_q + (SUM_W)'(rd_data_q.delay);
		end
		if (op == OP_OUT) begin
			result_q.coil_on <= energized_q;
			result_q.coil_direction <= energized_q ? cur_dir_q : DIR_NONE;
			result_q.off_event <= off_q;
			result_q.error_event <= err_q;
			result_q.queue_count <= fill_ext[QCNT_W-1:0];
		end
	end

endmodule

// ===== rtl/core/solenoid_pulse_scheduler_core.sv =====
// Channel   Dir  Width  Contents
// s_*       in   24     one command: action, delay_ticks, direction
// m_*       out  16     one result per command: coil state, events, queue count
// APB       in   32     registers two_point_mode, pulse_length, queue_enable
//
// A command is taken only while the controller is idle, so one command is in work at a time.
// Off, forget, immediate and dropped on commands finish directly. A tick steps the pulse,
// then the delay timer; on expiry it applies the pending direction and drains queued entries
// until the queue empties or the delay restarts. A queued on command sums queued delays
// over the queue memory read port, then writes its entry. A waiting result stalls the next
// command in its last cycle. arst_n clears all control state; queue memory is not reset.
module solenoid_pulse_scheduler_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata: [1:0] action, [17:2] delay_ticks, [19:18] direction, [23:20] zero
	input  logic [23:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: [0] coil_on, [2:1] coil_direction, [3] off_event, [4] error_event,
	// [8:5] queue_count, [15:9] zero
	output logic [15:0] m_tdata,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import sps_pkg::*;

	cfg_t    cfg_q;
	item_t   item;
	result_t result;
	stat_t   stat;
	op_t     op;
	logic    cfg_wr;

	// Register file; the host must write it only while no command is in work; the block does not enforce it.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_TWO_POINT: cfg_q.two_point <= pwdata[0];
				REG_PULSE_LEN: cfg_q.pulse_len <= pwdata[DLY_W-1:0];
				REG_QUEUE_EN:  cfg_q.queue_en <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_TWO_POINT: prdata = {31'd0, cfg_q.two_point};
			REG_PULSE_LEN: prdata = {16'd0, cfg_q.pulse_len};
			REG_QUEUE_EN:  prdata = {31'd0, cfg_q.queue_en};
			default:       prdata = '0;
		endcase
	end

	// Unpack the command fields, first field in the lowest bits.
	assign item.action      = s_tdata[1:0];
	assign item.delay_ticks = s_tdata[17:2];
	assign item.direction   = s_tdata[19:18];

	assign m_tdata = {7'd0, result.queue_count, result.error_event, result.off_event,
		result.coil_direction, result.coil_on};

	// The controller sequences each command as a short series of datapath operations.
	sps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.op       (op)
	);

	// The datapath holds the timers, the coil state and the command queue memory.
	sps_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.item   (item),
		.op     (op),
		.stat   (stat),
		.result (result)
	);

endmodule

// ===== rtl/core/sps_checker.sv =====
`include "solenoid_pulse_scheduler_core_defines.svh"

module sps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [23:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic [3:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata,
	input logic        pready
);
	import sps_pkg::*;

	logic cfg_wr_len;

	assign cfg_wr_len = psel && penable && pwrite && pready && (paddr[3:2] == REG_PULSE_LEN);

	`SPS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
	`SPS_ASSERT_SAME(a_dir_only_when_on, m_tvalid, m_tdata[0] || (m_tdata[2:1] == DIR_NONE), "direction shown with coil off")
	`SPS_ASSERT_NEXT(a_one_in_work, s_tvalid && s_tready, !s_tready, "second command taken while one is in work")
	`SPS_ASSERT_NEXT(a_len_readback, cfg_wr_len, (paddr[3:2] != REG_PULSE_LEN) || (prdata[15:0] == $past(pwdata[15:0])), "pulse length readback differs from write")

endmodule

bind solenoid_pulse_scheduler_core sps_checker u_sps_checker (.*);
